// ----- hdl/dbnh_pkg.sv -----
// ----------------------------------------------------------------------------
// dbnh_pkg: shared types and constants for the de Bruijn next-hop router
// Beat formats, register indexes and the per-stage division state.
// ----------------------------------------------------------------------------
package dbnh_pkg;

  // field widths fixed by the beat formats
  localparam int RANK_W    = 16;
  localparam int BASE_W    = 6;
  localparam int DCOUNT_W  = 5;
  localparam int NCOUNT_W  = 17;
  localparam int OVERLAP_W = 4;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  // restoring division: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS = 8;
  localparam int SUBSTAGES = RANK_W / DIV_STEPS;

  // width of power products before the range check
  localparam int PROD_W = NCOUNT_W + BASE_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd2;

  typedef struct packed {
    logic [RANK_W-1:0] current_rank;
    logic [RANK_W-1:0] destination_rank;
  } request_t;

  typedef struct packed {
    logic [RANK_W-1:0]    next_rank;
    logic [OVERLAP_W-1:0] overlap_length;
    logic                 bad_config;
  } result_t;

  // scalar state carried down the digit extraction pipeline
  typedef struct packed {
    logic                bad;    // rank out of range
    logic [RANK_W-1:0]   cq;     // current rank quotient in progress
    logic [RANK_W-1:0]   dq;     // destination rank quotient in progress
    logic [BASE_W-1:0]   cr;     // current partial remainder
    logic [BASE_W-1:0]   dr;     // destination partial remainder
    logic [NCOUNT_W-1:0] pf;     // running base power
    logic [NCOUNT_W-1:0] wt;     // base^(digit_count-1)
    logic                ovf;    // power exceeded node_count
    logic [RANK_W-1:0]   q1;     // current rank divided by base
  } div_state_t;

endpackage

// ----- hdl/dbnh_div_step.sv -----
// ----------------------------------------------------------------------------
// dbnh_div_step: eight restoring division steps
// Shifts dividend bits out of the top of q_in into the remainder built
// against the digit base; quotient bits enter at the bottom and q_out collects them.
// ----------------------------------------------------------------------------
module dbnh_div_step
  import dbnh_pkg::*;
(
  input  logic [RANK_W-1:0] q_in,
  input  logic [BASE_W-1:0] rem_in,
  input  logic [BASE_W-1:0] base,
  output logic [RANK_W-1:0] q_out,
  output logic [BASE_W-1:0] rem_out
);

  always_comb begin
    logic [BASE_W:0]   r;
    logic [RANK_W-1:0] q;
    logic [BASE_W-1:0] rem;
    q   = q_in;
    rem = rem_in;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {rem, q[RANK_W-1]};
      if (r >= {1'b0, base}) begin
        r = r - {1'b0, base};
        q = {q[RANK_W-2:0], 1'b1};
      end else begin
        q = {q[RANK_W-2:0], 1'b0};
      end
      rem = r[BASE_W-1:0];
    end
    q_out   = q;
    rem_out = rem;
  end

endmodule

// ----- hdl/de_bruijn_next_hop.sv -----
// ----------------------------------------------------------------------------
// de_bruijn_next_hop: next-hop router for a de Bruijn network
// Splits both ranks into base-symbol_base digits, finds the longest overlap
// of the current suffix with the destination prefix and forms the neighbor.
// ----------------------------------------------------------------------------
// Usage:
//   request channel carries current_rank and destination_rank; result
//   channel returns next_rank, overlap_length and bad_config. A beat moves
//   when valid is high and stall is low.
//   Configuration (symbol_base, digit_count, node_count) is written through
//   cfg_write / cfg_index / cfg_data while no beat is in flight.
// Throughput: one beat per cycle while a held result does not stall the
//   pipeline. The digit extraction follows the input register: each digit takes two
//   stages of eight restoring division steps, for both ranks side by side.
//   Four tail stages align digits, compare, pick the overlap and multiply.
// Reset clears every valid bit and loads symbol_base 2, digit_count 16 and
//   node_count 65536.
// When the receiver stalls a waiting result, the whole pipeline holds and
//   request_stall rises; nothing is dropped or repeated.
// A bad configuration or an out-of-range rank returns bad_config with zero
//   next_rank and overlap_length.
// ----------------------------------------------------------------------------
module de_bruijn_next_hop
  import dbnh_pkg::*;
#(
  parameter int MAX_DIGITS = 16,
  parameter int RANK_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 request_valid,
  output logic                 request_stall,
  input  request_t             request,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result
);

  localparam int NS = MAX_DIGITS * SUBSTAGES;
  localparam int KW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [32:0] RANK_SPAN = 33'(1) << RANK_BITS;

  typedef logic [MAX_DIGITS-1:0][BASE_W-1:0] digits_t;

  // configuration registers
  logic [BASE_W-1:0]   symbol_base;
  logic [DCOUNT_W-1:0] digit_count;
  logic [NCOUNT_W-1:0] node_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_base <= BASE_W'(2);
      digit_count <= DCOUNT_W'(16);
      node_count  <= NCOUNT_W'(65536);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SYMBOL_BASE: symbol_base <= cfg_data[BASE_W-1:0];
        REG_DIGIT_COUNT: digit_count <= cfg_data[DCOUNT_W-1:0];
        REG_NODE_COUNT:  node_count  <= cfg_data[NCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a result is held
  logic adv;
  assign adv           = !(result_valid && result_stall);
  assign request_stall = !adv;

  // digit extraction pipeline
  logic [NS:0] vld;
  div_state_t  st   [NS+1];
  digits_t     cdig [NS+1];
  digits_t     ddig [NS+1];

  // input register with range check
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= request_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].bad <= ({1'b0, request.current_rank} >= node_count) ||
                   ({1'b0, request.destination_rank} >= node_count);
      st[0].cq  <= request.current_rank;
      st[0].dq  <= request.destination_rank;
      st[0].cr  <= '0;
      st[0].dr  <= '0;
      st[0].pf  <= NCOUNT_W'(1);
      st[0].wt  <= '0;
      st[0].ovf <= 1'b0;
      st[0].q1  <= '0;
      cdig[0]   <= '0;
      ddig[0]   <= '0;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_div
    localparam int J   = s / SUBSTAGES;
    localparam int SUB = s % SUBSTAGES;

    div_state_t        nxt;
    logic [BASE_W-1:0] cr_in, dr_in, cr_out, dr_out;
    logic [RANK_W-1:0] cq_out, dq_out;
    digits_t           cnext, dnext;

    // a new digit starts from a zero remainder
    assign cr_in = (SUB == 0) ? '0 : st[s].cr;
    assign dr_in = (SUB == 0) ? '0 : st[s].dr;

    dbnh_div_step u_cur (
      .q_in(st[s].cq), .rem_in(cr_in), .base(symbol_base),
      .q_out(cq_out), .rem_out(cr_out)
    );
    dbnh_div_step u_dst (
      .q_in(st[s].dq), .rem_in(dr_in), .base(symbol_base),
      .q_out(dq_out), .rem_out(dr_out)
    );

    // one power step per digit, alongside the division
    always_comb begin
      logic [PROD_W-1:0] prod;
      nxt    = st[s];
      nxt.cq = cq_out;
      nxt.dq = dq_out;
      nxt.cr = cr_out;
      nxt.dr = dr_out;
      prod   = PROD_W'(st[s].pf) * PROD_W'(symbol_base);
      if (SUB == 0) begin
        if (J == int'(digit_count) - 1) nxt.wt = st[s].pf;
        if (J < int'(digit_count) && !st[s].ovf) begin
          if (prod > PROD_W'(node_count)) nxt.ovf = 1'b1;
          else                            nxt.pf  = prod[NCOUNT_W-1:0];
        end
      end
      if (s == SUBSTAGES - 1) nxt.q1 = cq_out;
    end

    // the finished remainder becomes this digit
    always_comb begin
      cnext = cdig[s];
      dnext = ddig[s];
      if (SUB == SUBSTAGES - 1) begin
        cnext[J] = cr_out;
        dnext[J] = dr_out;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[s+1]   <= nxt;
        cdig[s+1] <= cnext;
        ddig[s+1] <= dnext;
      end
    end
  end

  // tail 1: configuration check and top-aligned current digits
  logic              t1v, t1bad;
  digits_t           t1cur, t1dd;
  logic [RANK_W-1:0] t1q1;
  logic [NCOUNT_W-1:0] t1wt;
  digits_t           tcur;
  logic              cfg_bad;

  assign cfg_bad = st[NS].ovf || (st[NS].pf != node_count) ||
                   (symbol_base < BASE_W'(2)) || (digit_count == '0) ||
                   (int'(digit_count) > MAX_DIGITS) ||
                   ({16'b0, node_count} > RANK_SPAN);

  always_comb begin
    tcur = '0;
    for (int m = 0; m < MAX_DIGITS; m++) begin
      for (int c = 0; c < MAX_DIGITS; c++) begin
        if (c == int'(digit_count) - 1 - m) tcur[m] = cdig[NS][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1v <= 1'b0;
    end else if (adv) begin
      t1v <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1bad <= st[NS].bad || cfg_bad;
      t1cur <= tcur;
      t1dd  <= ddig[NS];
      t1q1  <= st[NS].q1;
      t1wt  <= st[NS].wt;
    end
  end

  // tail 2: overlap match for every length
  logic                  t2v, t2bad;
  logic [MAX_DIGITS-1:0] t2match, match;
  digits_t               t2dd;
  logic [RANK_W-1:0]     t2q1;
  logic [NCOUNT_W-1:0]   t2wt;

  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      match[k] = 1'b1;
      for (int i = 0; i < k; i++) begin
        if (t1cur[k-1-i] != t1dd[i]) match[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2v <= 1'b0;
    end else if (adv) begin
      t2v <= t1v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2bad   <= t1bad;
      t2match <= match;
      t2dd    <= t1dd;
      t2q1    <= t1q1;
      t2wt    <= t1wt;
    end
  end

  // tail 3: longest valid overlap
  logic                t3v, t3bad;
  logic [KW-1:0]       t3k, ksel;
  digits_t             t3dd;
  logic [RANK_W-1:0]   t3q1;
  logic [NCOUNT_W-1:0] t3wt;

  always_comb begin
    ksel = '0;
    for (int k = 1; k < MAX_DIGITS; k++) begin
      if (t2match[k] && (k < int'(digit_count))) ksel = KW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t3v <= 1'b0;
    end else if (adv) begin
      t3v <= t2v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t3bad <= t2bad;
      t3k   <= ksel;
      t3dd  <= t2dd;
      t3q1  <= t2q1;
      t3wt  <= t2wt;
    end
  end

  // tail 4: new top digit times its weight, plus the shifted rank
  logic [BASE_W-1:0] dk;
  logic [PROD_W-1:0] next_full;
  result_t           res_next;

  always_comb begin
    dk = '0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (t3k == KW'(k)) dk = t3dd[k];
    end
    next_full = PROD_W'(dk) * PROD_W'(t3wt) + PROD_W'(t3q1);
    if (t3bad) begin
      res_next = '{next_rank: '0, overlap_length: '0, bad_config: 1'b1};
    end else begin
      res_next.next_rank      = next_full[RANK_W-1:0];
      res_next.overlap_length = OVERLAP_W'(t3k);
      res_next.bad_config     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= t3v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) result <= res_next;
  end

  // checks
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_config |->
      (result.next_rank == '0) && (result.overlap_length == '0))
    else $error("bad_config beat carries nonzero fields");

  a_overlap_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.bad_config |->
      ({1'b0, result.overlap_length} < digit_count))
    else $error("overlap_length not below digit_count");

  a_next_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.bad_config |->
      ({1'b0, result.next_rank} < node_count))
    else $error("next_rank not below node_count");

endmodule
